### sv/srse_pkg.sv
// shared types, codes and defaults for the stack with reverse and end swap
package srse_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DEPTH_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_REVERSE = 3'd2,
    OP_SWAP    = 3'd3,
    OP_DUMP    = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SINGLE = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_value;
    logic                     last_of_run;
    logic [DEPTH_W-1:0]       depth_now;
  } out_t;

endpackage

### sv/srse_ram.sv
// generic single write, single read ram with registered read data
module srse_ram #(
  parameter int unsigned WIDTH = srse_pkg::DATA_W,
  parameter int unsigned DEPTH = srse_pkg::DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/stack_reverse_swap_ends_core.sv
// top level: bounded stack with push, pop, reverse, end swap and dump
//
// Input channel in_valid_i / in_stall_o carries one operation per transaction
// (op and push_value in in_data_i). Output channel out_valid_o / out_stall_i
// returns results in out_data_o: one per operation, or one per element for a
// dump, bottom first, with last_of_run set on the final result.
// The store is a circular buffer in one ram with one write and one read port;
// reverse only flips an orientation bit. A small sequencer steps each
// operation through the ram and one shared slot address adder.
// A swap makes two reads and two writes through the single ports and a dump
// one ram read per element; a pop or dump of an empty stack and a swap of
// fewer than two elements touch no ram.
// in_stall_o stays high from acceptance until the last result is loaded into
// the output register; the next operation is accepted while that result waits.
// A stalled receiver freezes out_q and holds the FSM in S_RESP or S_DUMP_EMIT.
// Reset (rst_ni low) empties the stack and clears the orientation; ram
// contents are not cleared and are only read after being written.
module stack_reverse_swap_ends_core #(
  parameter int unsigned DEPTH = srse_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned SW   = CW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srse_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output srse_pkg::out_t  out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_POP_RD    = 8'b0000_0010,
    S_SWAP_A    = 8'b0000_0100,
    S_SWAP_B    = 8'b0000_1000,
    S_SWAP_C    = 8'b0001_0000,
    S_RESP      = 8'b0010_0000,
    S_DUMP_RD   = 8'b0100_0000,
    S_DUMP_EMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] addr_a_q, addr_a_d;
  logic [AW-1:0] addr_b_q, addr_b_d;
  logic [srse_pkg::DATA_W-1:0] tmp_q, tmp_d;
  logic [srse_pkg::DATA_W-1:0] data_q, data_d;
  logic [srse_pkg::STATUS_W-1:0] st_q, st_d;
  srse_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [srse_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] u_pos, u_off;
  logic          u_rev;
  logic [SW-1:0] u_sum;
  logic [AW-1:0] slot;

  logic [AW-1:0] base_dec, base_inc;
  logic [CW-1:0] idx_next;
  logic          full, dump_last, out_free;
  logic [srse_pkg::STATUS_W-1:0] small_st;

  srse_ram #(
    .WIDTH (srse_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared slot address unit
  always_comb begin
    u_off = u_rev ? (count_q - CW'(1) - u_pos) : u_pos;
    u_sum = SW'(base_q) + SW'(u_off);
    if (u_sum >= SW'(DEPTH)) begin
      slot = AW'(u_sum - SW'(DEPTH));
    end else begin
      slot = AW'(u_sum);
    end
  end

  assign base_dec  = (base_q == AW'(0)) ? AW'(DEPTH - 1) : base_q - AW'(1);
  assign base_inc  = (base_q == AW'(DEPTH - 1)) ? AW'(0) : base_q + AW'(1);
  assign idx_next  = idx_q + CW'(1);
  assign full      = (count_q == CW'(DEPTH));
  assign dump_last = ({1'b0, idx_q} + SW'(1)) == {1'b0, count_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (count_q == CW'(0)) begin
      small_st = srse_pkg::ST_EMPTY;
    end else if (count_q == CW'(1)) begin
      small_st = srse_pkg::ST_SINGLE;
    end else begin
      small_st = srse_pkg::ST_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    count_d     = count_q;
    rev_d       = rev_q;
    idx_d       = idx_q;
    addr_a_d    = addr_a_q;
    addr_b_d    = addr_b_q;
    tmp_d       = tmp_q;
    data_d      = data_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = '0;
    u_pos       = '0;
    u_rev       = rev_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          data_d  = '0;
          state_d = S_RESP;
          unique case (in_data_i.op)
            srse_pkg::OP_PUSH: begin
              if (full) begin
                st_d = srse_pkg::ST_FULL;
              end else begin
                st_d      = srse_pkg::ST_OK;
                ram_we    = 1'b1;
                ram_wdata = in_data_i.push_value;
                count_d   = count_q + CW'(1);
                if (rev_q) begin
                  ram_waddr = base_dec;
                  base_d    = base_dec;
                end else begin
                  u_pos     = count_q;
                  u_rev     = 1'b0;
                  ram_waddr = slot;
                end
              end
            end
            srse_pkg::OP_POP: begin
              if (count_q == CW'(0)) begin
                st_d = srse_pkg::ST_EMPTY;
              end else begin
                st_d      = srse_pkg::ST_OK;
                u_pos     = count_q - CW'(1);
                ram_re    = 1'b1;
                ram_raddr = slot;
                count_d   = count_q - CW'(1);
                if (rev_q) begin
                  base_d = base_inc;
                end
                state_d = S_POP_RD;
              end
            end
            srse_pkg::OP_REVERSE: begin
              st_d = small_st;
              if (small_st == srse_pkg::ST_OK) begin
                rev_d = !rev_q;
              end
            end
            srse_pkg::OP_SWAP: begin
              st_d = small_st;
              if (small_st == srse_pkg::ST_OK) begin
                ram_re    = 1'b1;
                ram_raddr = slot;
                addr_a_d  = slot;
                state_d   = S_SWAP_A;
              end
            end
            srse_pkg::OP_DUMP: begin
              if (count_q == CW'(0)) begin
                st_d = srse_pkg::ST_EMPTY;
              end else begin
                st_d      = srse_pkg::ST_OK;
                ram_re    = 1'b1;
                ram_raddr = slot;
                idx_d     = '0;
                state_d   = S_DUMP_RD;
              end
            end
            default: begin
              st_d = srse_pkg::ST_OK;
            end
          endcase
        end
      end
      S_POP_RD: begin
        data_d  = ram_rdata;
        state_d = S_RESP;
      end
      S_SWAP_A: begin
        tmp_d     = ram_rdata;
        u_pos     = count_q - CW'(1);
        ram_re    = 1'b1;
        ram_raddr = slot;
        addr_b_d  = slot;
        state_d   = S_SWAP_B;
      end
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a_q;
        ram_wdata = ram_rdata;
        state_d   = S_SWAP_C;
      end
      S_SWAP_C: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_q;
        ram_wdata = tmp_q;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_d.status      = st_q;
          out_d.data_value  = data_q;
          out_d.last_of_run = 1'b1;
          out_d.depth_now   = srse_pkg::DEPTH_W'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        state_d = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (out_free) begin
          out_d.status      = srse_pkg::ST_OK;
          out_d.data_value  = ram_rdata;
          out_d.last_of_run = dump_last;
          out_d.depth_now   = srse_pkg::DEPTH_W'(count_q);
          out_valid_d       = 1'b1;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d     = idx_next;
            u_pos     = idx_next;
            ram_re    = 1'b1;
            ram_raddr = slot;
            state_d   = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    addr_a_q <= addr_a_d;
    addr_b_q <= addr_b_d;
    tmp_q    <= tmp_d;
    data_q   <= data_d;
    st_q     <= st_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/srse_checker.sv
// port level checks for the stack core, bound to the top level
module srse_checker #(
  parameter int unsigned DEPTH = srse_pkg::DEPTH_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input srse_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input srse_pkg::out_t out_data_o
);

  logic [srse_pkg::DEPTH_W-1:0] depth_full;

  assign depth_full = srse_pkg::DEPTH_W'(DEPTH);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == srse_pkg::ST_EMPTY)
    |-> (out_data_o.depth_now == '0) && out_data_o.last_of_run)
    else $error("empty status with nonzero depth");

  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == srse_pkg::ST_FULL)
    |-> (out_data_o.depth_now == depth_full) && out_data_o.last_of_run)
    else $error("full status with wrong depth");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != srse_pkg::ST_OK)
    |-> (out_data_o.data_value == '0))
    else $error("nonzero data on refused transaction");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o || (in_data_i.op != in_data_i.op))
    else $error("input accepted on consecutive cycles");

endmodule

bind stack_reverse_swap_ends_core srse_checker #(
  .DEPTH (DEPTH)
) u_srse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
